/* hw/rtl/mmcs_pkg.sv */
package mmcs_pkg;

    // pixel and buffer geometry
    localparam int PIX_W      = 16;
    localparam int MAX_PIXELS = 4096;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;

    // divider step counter holds 0 .. PIX_W
    localparam int DIV_CNT_W  = $clog2(PIX_W + 1);

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FLAT  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_TRUNC = 2'd3
    } status_t;

    // input command codes
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 2'd1;

    localparam logic [PIX_W-1:0] TARGET_LOW_RST  = '0;
    localparam logic [PIX_W-1:0] TARGET_HIGH_RST = '1;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/min_max_contrast_stretch_unit.sv */
// Min-max contrast stretch. Words with s_tuser = 0 load s_tdata as one pixel into a
// 4096-entry buffer while the running minimum and maximum are tracked; a load is written
// while the block stays idle and ready, and loads past capacity are dropped and flagged.
// A word with s_tuser = 1 requests the next stored pixel, returned on m_tdata as
// (p - min) * (target_high - target_low) / (max - min) + target_low, truncated toward
// zero, with m_tlast on the final pixel of the image and m_tuser giving the status
// (0 ok, 1 flat image, 2 empty buffer, 3 image was truncated). A read passes through
// one buffer read, one subtract, one multiply and a bit-serial divider that yields one
// quotient bit per cycle, then the output register; flat and empty reads skip the
// divider. One item is worked on at a time. The first load after any read starts a fresh
// image. target_low and target_high are written through the cfg port (index 0 and 1);
// the user must write them only while the block is idle; the block does not enforce it.
module min_max_contrast_stretch_unit
    import mmcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,    // [15:0] pixel_in
    input  logic                 s_tuser,    // [0] cmd
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,    // [15:0] pixel_out
    output logic                 m_tlast,
    output logic [STAT_W-1:0]    m_tuser,    // [1:0] status
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    pixel_count_reg, pixel_count_next;
    logic [ADDR_W-1:0]   read_index_reg, read_index_next;
    logic [PIX_W-1:0]    found_min_reg, found_min_next;
    logic [PIX_W-1:0]    found_max_reg, found_max_next;
    logic                reading_reg, reading_next;
    logic                overflow_reg, overflow_next;
    logic [PIX_W-1:0]    target_low_reg, target_high_reg;

    // per-read working values
    status_t             status_reg, status_next;
    logic                last_reg, last_next;
    logic [PIX_W-1:0]    num_reg;
    logic [PIX_W-1:0]    span_mag_reg;
    logic                span_neg_reg;
    logic [PIX_W-1:0]    rd_data_reg;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [PIX_W-1:0]    m_tdata_reg;
    logic                m_tlast_reg;
    status_t             m_status_reg;

    logic [PIX_W-1:0]    pixel_store [MAX_PIXELS];

    logic                in_fire;
    logic                cmd_read;
    logic [CNT_W-1:0]    count_eff;
    logic                buf_full;
    logic                wr_en;
    logic                out_load;
    logic [PIX_W:0]      span;
    logic [PROD_W-1:0]   product;
    logic                div_start;
    logic                div_done;
    logic [PIX_W-1:0]    quotient;
    logic [PIX_W-1:0]    result;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign cmd_read  = (s_tuser == CMD_READ);

    // a load after reads starts a fresh image
    assign count_eff = reading_reg ? '0 : pixel_count_reg;
    assign buf_full  = (count_eff == CNT_W'(MAX_PIXELS));

    // signed span of the targets as sign and magnitude
    assign span      = {1'b0, target_high_reg} - {1'b0, target_low_reg};
    assign product   = num_reg * span_mag_reg;
    assign div_start = (state_reg == ST_MUL);

    mmcs_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (found_max_reg - found_min_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // final value for the current read
    always_comb begin
        if (status_reg == STAT_EMPTY) begin
            result = '0;
        end else if (status_reg == STAT_FLAT) begin
            result = target_low_reg;
        end else if (span_neg_reg) begin
            result = target_low_reg - quotient;
        end else begin
            result = target_low_reg + quotient;
        end
    end

    // sequencer and image bookkeeping
    always_comb begin
        state_next       = state_reg;
        pixel_count_next = pixel_count_reg;
        read_index_next  = read_index_reg;
        found_min_next   = found_min_reg;
        found_max_next   = found_max_reg;
        reading_next     = reading_reg;
        overflow_next    = overflow_reg;
        status_next      = status_reg;
        last_next        = last_reg;
        wr_en            = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && !cmd_read) begin
                    if (reading_reg) begin
                        read_index_next = '0;
                        overflow_next   = 1'b0;
                        reading_next    = 1'b0;
                    end
                    pixel_count_next = count_eff;
                    if (buf_full) begin
                        overflow_next = 1'b1;
                    end else begin
                        wr_en            = 1'b1;
                        pixel_count_next = count_eff + CNT_W'(1);
                        if (count_eff == '0 || s_tdata < found_min_reg) begin
                            found_min_next = s_tdata;
                        end
                        if (count_eff == '0 || s_tdata > found_max_reg) begin
                            found_max_next = s_tdata;
                        end
                    end
                end else if (in_fire) begin
                    if (pixel_count_reg == '0) begin
                        status_next = STAT_EMPTY;
                        last_next   = 1'b0;
                        state_next  = ST_DONE;
                    end else begin
                        reading_next = 1'b1;
                        last_next    = ({1'b0, read_index_reg} ==
                                        pixel_count_reg - CNT_W'(1));
                        read_index_next = last_next ? '0 : read_index_reg + ADDR_W'(1);
                        if (found_max_reg == found_min_reg) begin
                            status_next = STAT_FLAT;
                        end else if (overflow_reg) begin
                            status_next = STAT_TRUNC;
                        end else begin
                            status_next = STAT_OK;
                        end
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = (status_reg == STAT_FLAT) ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_tvalid_next = (m_tvalid_reg && !m_tready) || out_load;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pixel_count_reg <= '0;
            read_index_reg  <= '0;
            found_min_reg   <= '0;
            found_max_reg   <= '0;
            reading_reg     <= 1'b0;
            overflow_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            target_low_reg  <= TARGET_LOW_RST;
            target_high_reg <= TARGET_HIGH_RST;
        end else begin
            state_reg       <= state_next;
            pixel_count_reg <= pixel_count_next;
            read_index_reg  <= read_index_next;
            found_min_reg   <= found_min_next;
            found_max_reg   <= found_max_next;
            reading_reg     <= reading_next;
            overflow_reg    <= overflow_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TARGET_LOW:  target_low_reg  <= cfg_data;
                    CFG_TARGET_HIGH: target_high_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // pixel buffer, registered read at the current read index
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pixel_store[count_eff[ADDR_W-1:0]] <= s_tdata;
        end
        rd_data_reg <= pixel_store[read_index_reg];
    end

    // per-read datapath
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        last_reg   <= last_next;
        if (state_reg == ST_FETCH) begin
            num_reg      <= rd_data_reg - found_min_reg;
            span_neg_reg <= span[PIX_W];
            span_mag_reg <= span[PIX_W] ? PIX_W'(-span) : span[PIX_W-1:0];
        end
        if (out_load) begin
            m_tdata_reg  <= result;
            m_tlast_reg  <= last_reg;
            m_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_status_reg;

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside of the divide phase");

    // fill level never passes capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        pixel_count_reg <= CNT_W'(MAX_PIXELS))
        else $error("pixel count above buffer capacity");

    // read pointer stays inside the stored image
    a_index_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        (pixel_count_reg != '0) |-> ({1'b0, read_index_reg} < pixel_count_reg))
        else $error("read index outside stored image");

    // an empty read returns zero and no last mark
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_EMPTY) |-> (m_tdata == '0 && !m_tlast))
        else $error("empty read with nonzero result");

endmodule

/* hw/rtl/mmcs_serial_div.sv */
module mmcs_serial_div
    import mmcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [PIX_W-1:0]  divisor,
    output logic              done,
    output logic [PIX_W-1:0]  quotient
);

    // restoring division, one quotient bit per cycle; the quotient is known
    // to fit in PIX_W bits, so the upper half of the dividend starts as remainder
    logic [PIX_W-1:0]     rem_reg, rem_next;
    logic [PIX_W-1:0]     shf_reg, shf_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [PIX_W:0]       trial;
    logic [PIX_W+1:0]     diff;
    logic                 ge;

    // one trial subtract per step
    always_comb begin
        trial     = {rem_reg, shf_reg[PIX_W-1]};
        diff      = {1'b0, trial} - {2'b00, divisor};
        ge        = ~diff[PIX_W+1];
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = dividend[PROD_W-1:PIX_W];
            shf_next = dividend[PIX_W-1:0];
            cnt_next = DIV_CNT_W'(PIX_W);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
            shf_next  = {shf_reg[PIX_W-2:0], ge};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
    end

    assign done     = done_reg;
    assign quotient = shf_reg;

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import mmcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned READ_LATENCY = 25;

    // indexes with no register behind them, written to show they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // pixel loading styles
    localparam int STYLE_WIDE    = 0;
    localparam int STYLE_NARROW  = 1;
    localparam int STYLE_EXTREME = 2;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
        status_t          st;
    } stretch_result_t;

    // tracks the image buffer and the targets, predicts every stretched pixel
    class stretch_checker;
        logic [PIX_W-1:0] pixels [MAX_PIXELS];
        int unsigned      n_stored;
        int unsigned      rd_ptr;
        logic [PIX_W-1:0] lo_seen;
        logic [PIX_W-1:0] hi_seen;
        bit               reading;
        bit               truncated;
        logic [PIX_W-1:0] tgt_low;
        logic [PIX_W-1:0] tgt_high;
        stretch_result_t  pending_pixels[$];
        int unsigned      errors;

        function new();
            n_stored  = 0;
            rd_ptr    = 0;
            lo_seen   = '0;
            hi_seen   = '0;
            reading   = 0;
            truncated = 0;
            tgt_low   = TARGET_LOW_RST;
            tgt_high  = TARGET_HIGH_RST;
            errors    = 0;
        endfunction

        function void set_target(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] val);
            if (idx == CFG_TARGET_LOW) begin
                tgt_low = val;
            end else if (idx == CFG_TARGET_HIGH) begin
                tgt_high = val;
            end
        endfunction

        // one accepted input word
        function void absorb_word(cmd_t c, logic [PIX_W-1:0] p);
            stretch_result_t r;
            logic [PIX_W-1:0] px;
            longint num, span, spread, q;
            if (c == CMD_LOAD) begin
                // first load after reads opens a fresh image
                if (reading) begin
                    n_stored  = 0;
                    rd_ptr    = 0;
                    truncated = 0;
                    reading   = 0;
                end
                if (n_stored >= MAX_PIXELS) begin
                    truncated = 1;
                    return;
                end
                if (n_stored == 0) begin
                    lo_seen = p;
                    hi_seen = p;
                end else begin
                    if (p < lo_seen) lo_seen = p;
                    if (p > hi_seen) hi_seen = p;
                end
                pixels[n_stored] = p;
                n_stored++;
                return;
            end
            // read with nothing stored
            if (n_stored == 0) begin
                r.pix  = '0;
                r.last = 1'b0;
                r.st   = STAT_EMPTY;
                pending_pixels = {pending_pixels, r};
                return;
            end
            reading = 1;
            if (rd_ptr >= n_stored) rd_ptr = 0;
            px     = pixels[rd_ptr];
            r.last = (rd_ptr == n_stored - 1);
            if (hi_seen == lo_seen) begin
                r.pix = tgt_low;
                r.st  = STAT_FLAT;
            end else begin
                num    = longint'(px) - longint'(lo_seen);
                span   = longint'(tgt_high) - longint'(tgt_low);
                spread = longint'(hi_seen) - longint'(lo_seen);
                q      = (num * span) / spread + longint'(tgt_low);
                r.pix  = q[PIX_W-1:0];
                r.st   = truncated ? STAT_TRUNC : STAT_OK;
            end
            rd_ptr = r.last ? 0 : rd_ptr + 1;
            pending_pixels = {pending_pixels, r};
        endfunction

        // one accepted result word against the oldest prediction
        function void check_pixel(logic [PIX_W-1:0] d, logic l, logic [STAT_W-1:0] s);
            stretch_result_t r;
            if (pending_pixels.size() == 0) begin
                $error("result word with no prediction pending: pixel_out %0d", d);
                errors++;
                return;
            end
            r = pending_pixels.pop_front();
            if (d !== r.pix) begin
                $error("pixel_out expected %0d got %0d", r.pix, d);
                errors++;
            end
            if (l !== r.last) begin
                $error("last_pixel expected %0d got %0d", r.last, l);
                errors++;
            end
            if (s !== r.st) begin
                $error("status expected %0d got %0d", r.st, s);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata;    // [15:0] pixel_in
    logic                 s_tuser;    // [0] cmd
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PIX_W-1:0]     m_tdata;    // [15:0] pixel_out
    logic                 m_tlast;
    logic [STAT_W-1:0]    m_tuser;    // [1:0] status
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PIX_W-1:0]     cfg_data;

    stretch_checker chk = new();
    int unsigned    cycles = 0;
    int unsigned    items_sent = 0;
    int unsigned    tx_idle_pct = 8;
    int unsigned    rx_idle_pct = 48;

    min_max_contrast_stretch_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
    end

    // watchdog
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("[min_max_contrast_stretch_unit] ERROR");
        $finish;
    end

    // result side backpressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            chk.check_pixel(m_tdata, m_tlast, m_tuser);
        end
    end

    // one input word, with random gaps before it
    task automatic send_word(input cmd_t c, input logic [PIX_W-1:0] p);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = p;
        s_tuser  = c;
        do @(posedge aclk); while (!s_tready);
        chk.absorb_word(c, p);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        chk.set_target(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // hold the sender until every predicted result has come back
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (chk.pending_pixels.size() != 0) @(negedge aclk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (READ_LATENCY) @(negedge aclk);
    endtask

    task automatic load_image(input int unsigned n, input int style);
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] p;
        base = PIX_W'($urandom_range(0, 65532));
        repeat (n) begin
            case (style)
                STYLE_NARROW:  p = base + PIX_W'($urandom_range(0, 3));
                STYLE_EXTREME: p = $urandom_range(0, 1) ? '1 : '0;
                default:       p = PIX_W'($urandom);
            endcase
            send_word(CMD_LOAD, p);
        end
    endtask

    task automatic read_pixels(input int unsigned n);
        repeat (n) send_word(CMD_READ, PIX_W'($urandom));
    endtask

    // mostly whole images with random content, some loose noise words
    task automatic run_phase(input int unsigned quota, input bit with_overflow);
        int unsigned stop_at;
        int unsigned n;
        int unsigned k;
        if (with_overflow) begin
            load_image(MAX_PIXELS + 3, STYLE_WIDE);
            read_pixels(5);
        end
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 75) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
                load_image(n, $urandom_range(STYLE_WIDE, STYLE_EXTREME));
                case ($urandom_range(0, 3))
                    0:       k = $urandom_range(1, n);
                    1:       k = n + $urandom_range(1, n);
                    default: k = n;
                endcase
                read_pixels(k);
                if ($urandom_range(0, 9) == 0) wait_drained();
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_word(cmd_t'($urandom_range(0, 1)), PIX_W'($urandom));
                end
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_LOAD;
        cfg_valid = 1'b0;
        cfg_index = CFG_TARGET_LOW;
        cfg_data  = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // read before any load, then extremes with a replay past the end
        send_word(CMD_READ, '1);
        send_word(CMD_LOAD, 16'd0);
        send_word(CMD_LOAD, 16'hFFFF);
        send_word(CMD_LOAD, 16'd1234);
        read_pixels(4);
        // single pixel image is flat
        send_word(CMD_LOAD, 16'd5);
        read_pixels(2);

        // falling mapping
        settle();
        write_reg(CFG_TARGET_LOW, 16'hFFFF);
        write_reg(CFG_TARGET_HIGH, 16'd0);
        send_word(CMD_LOAD, 16'd100);
        send_word(CMD_LOAD, 16'd300);
        send_word(CMD_LOAD, 16'd200);
        send_word(CMD_LOAD, 16'd101);
        read_pixels(4);

        // writes to unused indexes change nothing, flat image of equal pixels
        settle();
        write_reg(CFG_SPARE_A, PIX_W'($urandom));
        write_reg(CFG_SPARE_B, PIX_W'($urandom));
        send_word(CMD_LOAD, 16'd7);
        send_word(CMD_LOAD, 16'd7);
        read_pixels(2);

        // random phases; targets and idling mix are set per phase
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(CFG_TARGET_LOW, 16'd0);
                    write_reg(CFG_TARGET_HIGH, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_TARGET_LOW, 16'hFFFF);
                    write_reg(CFG_TARGET_HIGH, 16'd0);
                end
                2: begin
                    write_reg(CFG_TARGET_LOW, 16'd0);
                    write_reg(CFG_TARGET_HIGH, 16'd0);
                end
                3: begin
                    write_reg(CFG_TARGET_LOW, 16'hFFFF);
                    write_reg(CFG_TARGET_HIGH, 16'hFFFF);
                end
                default: begin
                    write_reg(CFG_TARGET_LOW, PIX_W'($urandom));
                    write_reg(CFG_TARGET_HIGH, PIX_W'($urandom));
                end
            endcase
            if (ph < 2) begin
                tx_idle_pct = 8;
                rx_idle_pct = 48;
            end else if (ph < 4) begin
                tx_idle_pct = 48;
                rx_idle_pct = 8;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            run_phase(200, ph == 4);
        end

        // drain and let the block go quiet
        wait_drained();
        repeat (READ_LATENCY * 2) @(negedge aclk);
        chk.errors += chk.pending_pixels.size();
        if (chk.errors == 0) begin
            $display("[min_max_contrast_stretch_unit] OK");
        end else begin
            $display("[min_max_contrast_stretch_unit] ERROR");
        end
        $finish;
    end

endmodule
